// ----- src/fte_pkg.sv -----
// shared types and constants of the flow table engine
`timescale 1ns / 1ps
package fte_pkg;
  localparam int unsigned Buckets = 256;
  localparam int unsigned Ways = 4;
  localparam int unsigned Slots = Buckets * Ways;
  localparam int unsigned BucketW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CountW = 11;
  localparam int unsigned TopByteShift = 24;
  localparam logic [31:0] MinBytes = 32'd2;
  // key, byte counts and flags of one stored flow
  localparam int unsigned RecW = 64 + 32 + 32 + 32 + 2;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CLASS_DEADLINE = 2'd0,
    CLASS_SIZED    = 2'd1,
    CLASS_UNKNOWN  = 2'd2
  } class_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] local_addr;
    logic [31:0] remote_addr;
    logic [15:0] local_portnum;
    logic [15:0] remote_portnum;
    logic [31:0] sent_bytes_in;
    logic [31:0] total_bytes_in;
    logic        size_known_in;
    logic        deadline_known_in;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] delete_value;
    logic [1:0]  flow_class;
    logic [31:0] sent_bytes_out;
    logic [31:0] total_bytes_out;
    logic        size_known_out;
    logic        deadline_known_out;
    logic [CountW-1:0] flow_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [31:0] sent;
    logic [31:0] total;
    logic [1:0]  flags;
  } rec_t;
endpackage

// ----- src/fte_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module fte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- src/fte_hash.sv -----
// bucket hash: three chained 32-bit multiplies through one shared multiplier
`timescale 1ns / 1ps
module fte_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  fte_pkg::req_t                req_i,
  output logic                         done_o,
  output logic [fte_pkg::BucketW-1:0]  bucket_o
);
  import fte_pkg::*;

  logic [1:0]  step_q, step_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] opnd;
  logic [31:0] prod;

  always_comb begin
    unique case (step_q)
      2'd0:    opnd = {24'd0, req_i.remote_addr[31:TopByteShift]} + 32'd1;
      2'd1:    opnd = {16'd0, req_i.local_portnum} + 32'd1;
      default: opnd = {16'd0, req_i.remote_portnum} + 32'd1;
    endcase
  end

  assign prod = acc_q * opnd;

  always_comb begin
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    if (start_i) begin
      acc_d  = {24'd0, req_i.local_addr[31:TopByteShift]} + 32'd1;
      step_d = 2'd0;
      run_d  = 1'b1;
    end else if (run_q) begin
      acc_d = prod;
      if (step_q == 2'd2) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // buckets is not assumed a power of two
  assign bucket_o = BucketW'(acc_q % Buckets);
  assign done_o   = done_q;
endmodule

// ----- src/flow_table_engine.sv -----
// top level of the flow table engine: sequencer, way scan and record store
`timescale 1ns / 1ps
// One command at a time. A command is taken when start is high and busy low;
// its result appears on result_o for one cycle with done_o high, and cannot be
// held off. The key hash runs as three passes through one 32-bit multiplier,
// then the ways of the bucket are read one after another from the record ram
// (registered read: each way is addressed in the read state and checked in the
// check state), then the act state updates the store and registers the reply,
// and the reply state raises done_o. The next command is taken only once done_o
// has fallen, so a command is never taken before the last result is out. After
// reset a clearing pass over all Slots entries empties the valid store before the
// first command is taken.
module flow_table_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  fte_pkg::req_t   req_i,
  output logic            done_o,
  output fte_pkg::rsp_t   result_o
);
  import fte_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_CHECK, ST_ACT, ST_REPLY
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [SlotW-1:0]  clr_q;
  logic [WayW:0]     way_q;       // ways issued
  logic [WayW:0]     chk_q;       // ways checked
  logic [BucketW-1:0] bkt_q;
  logic              found_q, have_free_q;
  logic [WayW-1:0]   hit_q, free_q;
  rec_t              hit_rec_q;
  logic [CountW-1:0] count_q, count_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q;

  logic              accept;
  req_t              hash_req;
  logic              hash_done;
  logic [BucketW-1:0] bucket;
  logic              vld_we, vld_wd, vld_rd;
  logic              rec_we;
  logic [SlotW-1:0]  vld_addr, rec_addr;
  rec_t              rec_wd, rec_rd;
  rec_t              new_rec;
  logic              key_eq;

  assign accept = start && !busy;
  // the held command feeds the hash once the transfer is done
  assign hash_req = accept ? req_i : req_q;

  fte_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .req_i   (hash_req),
    .done_o  (hash_done),
    .bucket_o(bucket)
  );

  function automatic logic [SlotW-1:0] slot_of(logic [BucketW-1:0] b, logic [WayW-1:0] w);
    logic [SlotW+WayW:0] s;
    s = (SlotW + WayW + 1)'(b) * (SlotW + WayW + 1)'(Ways) + (SlotW + WayW + 1)'(w);
    return s[SlotW-1:0];
  endfunction

  assign new_rec = '{addrs: {req_q.local_addr, req_q.remote_addr},
                     ports: {req_q.local_portnum, req_q.remote_portnum},
                     sent: req_q.sent_bytes_in, total: req_q.total_bytes_in,
                     flags: {req_q.deadline_known_in, req_q.size_known_in}};

  assign key_eq = (rec_rd.addrs == new_rec.addrs) && (rec_rd.ports == new_rec.ports);

  always_comb begin
    vld_we   = 1'b0;
    vld_wd   = 1'b0;
    rec_we   = 1'b0;
    rec_wd   = new_rec;
    vld_addr = slot_of(bkt_q, way_q[WayW-1:0]);
    rec_addr = vld_addr;
    unique case (state_q)
      ST_CLEAR: begin
        vld_we   = 1'b1;
        vld_addr = clr_q;
      end
      ST_READ: begin
        if (!way_q[WayW] && !(way_q == (WayW+1)'(Ways))) begin
          vld_addr = slot_of(bkt_q, way_q[WayW-1:0]);
        end
      end
      ST_ACT: begin
        if (req_q.func == FUNC_INSERT && !found_q && have_free_q) begin
          vld_we   = 1'b1;
          vld_wd   = 1'b1;
          rec_we   = 1'b1;
          vld_addr = slot_of(bkt_q, free_q);
        end else if (req_q.func == FUNC_DELETE && found_q) begin
          vld_we   = 1'b1;
          vld_addr = slot_of(bkt_q, hit_q);
        end
        rec_addr = vld_addr;
      end
      default: ;
    endcase
  end

  fte_ram #(.Width(1), .Depth(Slots)) u_vld (
    .clk_i(clk_i), .we_i(vld_we), .addr_i(vld_addr), .wdata_i(vld_wd), .rdata_o(vld_rd)
  );

  fte_ram #(.Width(RecW), .Depth(Slots)) u_rec (
    .clk_i(clk_i), .we_i(rec_we), .addr_i(rec_addr), .wdata_i(rec_wd), .rdata_o(rec_rd)
  );

  // reply and count of the command held in req_q
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    unique case (req_q.func)
      FUNC_INSERT: begin
        if (!found_q && have_free_q) begin
          rsp_d.ok = 1'b1;
          count_d  = count_q + CountW'(1);
        end
      end
      FUNC_SEARCH: begin
        if (found_q) begin
          rsp_d.ok                 = 1'b1;
          rsp_d.sent_bytes_out     = hit_rec_q.sent;
          rsp_d.total_bytes_out    = hit_rec_q.total;
          rsp_d.size_known_out     = hit_rec_q.flags[0];
          rsp_d.deadline_known_out = hit_rec_q.flags[1];
        end
      end
      FUNC_DELETE: begin
        if (found_q) begin
          rsp_d.ok = 1'b1;
          count_d  = count_q - CountW'(1);
          if (hit_rec_q.flags[1]) begin
            rsp_d.delete_value = 32'd1;
            rsp_d.flow_class   = CLASS_DEADLINE;
          end else if (hit_rec_q.flags[0]) begin
            rsp_d.delete_value = (hit_rec_q.total > MinBytes) ? hit_rec_q.total
                                                               : MinBytes;
            rsp_d.flow_class   = CLASS_SIZED;
          end else begin
            rsp_d.delete_value = (hit_rec_q.sent > MinBytes) ? hit_rec_q.sent
                                                              : MinBytes;
            rsp_d.flow_class   = CLASS_UNKNOWN;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      way_q       <= '0;
      chk_q       <= '0;
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      hit_q       <= '0;
      free_q      <= '0;
      hit_rec_q   <= '0;
      count_q     <= '0;
      rsp_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= (state_q == ST_REPLY);
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SlotW'(1);
          if (clr_q == SlotW'(Slots - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            way_q       <= '0;
            chk_q       <= '0;
            found_q     <= 1'b0;
            have_free_q <= 1'b0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: begin
          // issue address for way_q; data arrives next cycle
          way_q   <= way_q + (WayW+1)'(1);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (vld_rd) begin
            if (!found_q && key_eq) begin
              found_q   <= 1'b1;
              hit_q     <= chk_q[WayW-1:0];
              hit_rec_q <= rec_rd;
            end
          end else if (!have_free_q) begin
            have_free_q <= 1'b1;
            free_q      <= chk_q[WayW-1:0];
          end
          chk_q <= chk_q + (WayW+1)'(1);
          if (way_q == (WayW+1)'(Ways)) begin
            state_q <= ST_ACT;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_ACT: begin
          rsp_q   <= rsp_d;
          count_q <= count_d;
          state_q <= ST_REPLY;
        end
        ST_REPLY: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_HASH && hash_done) begin
      bkt_q <= bucket;
    end
  end

  always_comb begin
    result_o            = rsp_q;
    result_o.flow_count = count_q;
  end

  assign done_o = done_q;
  assign busy   = (state_q != ST_IDLE) || done_q;

  // no transfer while the store is being cleared
  a_no_start_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> busy) else $error("busy low during clear");
  // a result strobe is followed by a ready engine
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE)) else $error("result without return to idle");
  // the count changes only in the act state, where a command moves it by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ACT) |=> $stable(count_q)) else $error("flow count changed outside act");
endmodule
